[hw/rtl/lmcp_pkg.sv]
// Shared widths, codes and types of the LED matrix cursor painter.
package lmcp_pkg;

	localparam int ActW    = 2;
	localparam int CodeW   = 4;
	localparam int CoordW  = 4;
	localparam int PatW    = 16;
	localparam int RowIdxW = 3;
	localparam int ByteW   = 8;
	localparam int CfgW    = 32;
	localparam int PaddrW  = 4;

	// request actions
	localparam logic [ActW-1:0] ACT_JOY  = 2'd0;
	localparam logic [ActW-1:0] ACT_BTN  = 2'd1;
	localparam logic [ActW-1:0] ACT_SCAN = 2'd2;

	// joystick codes, two per direction
	localparam logic [CodeW-1:0] JOY_COL_INC_A = 4'd1;
	localparam logic [CodeW-1:0] JOY_COL_INC_B = 4'd2;
	localparam logic [CodeW-1:0] JOY_COL_DEC_A = 4'd3;
	localparam logic [CodeW-1:0] JOY_COL_DEC_B = 4'd4;
	localparam logic [CodeW-1:0] JOY_ROW_INC_A = 4'd5;
	localparam logic [CodeW-1:0] JOY_ROW_INC_B = 4'd6;
	localparam logic [CodeW-1:0] JOY_ROW_DEC_A = 4'd7;
	localparam logic [CodeW-1:0] JOY_ROW_DEC_B = 4'd8;

	// configuration register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_ROW_MIN = 2'd0;
	localparam logic [1:0] REG_ROW_MAX = 2'd1;
	localparam logic [1:0] REG_COL_MIN = 2'd2;
	localparam logic [1:0] REG_COL_MAX = 2'd3;

	localparam logic [CoordW-1:0] COORD_ONE   = 4'd1;
	localparam logic [CoordW-1:0] COORD_EIGHT = 4'd8;

	typedef struct packed {
		logic [CoordW-1:0] row_min;
		logic [CoordW-1:0] row_max;
		logic [CoordW-1:0] col_min;
		logic [CoordW-1:0] col_max;
	} bounds_t;

endpackage

[hw/rtl/lmcp_req_if.sv]
// Request channel: action and joystick code with valid/ready.
interface lmcp_req_if;
	logic                       valid;
	logic                       ready;
	logic [lmcp_pkg::ActW-1:0]  action;
	logic [lmcp_pkg::CodeW-1:0] joystick_code;

	modport source (output valid, action, joystick_code, input ready);
	modport sink (input valid, action, joystick_code, output ready);
endinterface

[hw/rtl/lmcp_rsp_if.sv]
// Result channel: one row pattern per scan request with valid/ready.
interface lmcp_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [lmcp_pkg::PatW-1:0]    row_pattern;
	logic [lmcp_pkg::RowIdxW-1:0] row_index;
	logic                         last_row;
	logic [lmcp_pkg::CoordW-1:0]  cursor_row;
	logic [lmcp_pkg::CoordW-1:0]  cursor_col;

	modport source (output valid, row_pattern, row_index, last_row, cursor_row, cursor_col,
		input ready);
	modport sink (input valid, row_pattern, row_index, last_row, cursor_row, cursor_col,
		output ready);
endinterface

[hw/rtl/lmcp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lmcp_ram #(
	parameter int Width = 16,
	parameter int Depth = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/lmcp_cfg.sv]
// APB register bank holding the cursor boundary registers.
module lmcp_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lmcp_pkg::PaddrW-1:0]   paddr,
	input  logic [lmcp_pkg::CfgW-1:0]     pwdata,
	output logic [lmcp_pkg::CfgW-1:0]     prdata,
	output logic                          pready,
	output lmcp_pkg::bounds_t             bounds
);

	lmcp_pkg::bounds_t bounds_q;
	logic              wr_en;
	logic [1:0]        reg_idx;
	logic [lmcp_pkg::CoordW-1:0] wval;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign wval    = pwdata[lmcp_pkg::CoordW-1:0];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounds_q.row_min <= lmcp_pkg::COORD_ONE;
			bounds_q.row_max <= lmcp_pkg::COORD_EIGHT;
			bounds_q.col_min <= lmcp_pkg::COORD_ONE;
			bounds_q.col_max <= lmcp_pkg::COORD_EIGHT;
		end else if (wr_en) begin
			case (reg_idx)
				lmcp_pkg::REG_ROW_MIN: bounds_q.row_min <= wval;
				lmcp_pkg::REG_ROW_MAX: bounds_q.row_max <= wval;
				lmcp_pkg::REG_COL_MIN: bounds_q.col_min <= wval;
				lmcp_pkg::REG_COL_MAX: bounds_q.col_max <= wval;
				default: bounds_q <= bounds_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			lmcp_pkg::REG_ROW_MIN: prdata = lmcp_pkg::CfgW'(bounds_q.row_min);
			lmcp_pkg::REG_ROW_MAX: prdata = lmcp_pkg::CfgW'(bounds_q.row_max);
			lmcp_pkg::REG_COL_MIN: prdata = lmcp_pkg::CfgW'(bounds_q.col_min);
			lmcp_pkg::REG_COL_MAX: prdata = lmcp_pkg::CfgW'(bounds_q.col_max);
			default: prdata = '0;
		endcase
	end

	assign bounds = bounds_q;

endmodule

[hw/rtl/led_matrix_cursor_painter_top.sv]
// Top level of the LED matrix cursor painter: cursor, row store and scan output.
//
// The block takes one request per clock cycle, back to back, while no scan waits in the
// read stage for a full output register, and returns one result for each scan request
// through the row-store read stage and then the output register. A joystick request
// moves the one-based cursor one step inside the boundary registers, a button request
// flips the toggled pixel under the cursor, and a scan request returns the pattern word
// of the next row of the frame. The bitmaps live in one GRID_SIZE-deep RAM, one row per
// entry ({toggled, cursor}); each request touches at most one row, read at acceptance
// and written back in the cycle after, so the single write port of that RAM sets the
// rate of one request per cycle. A write that lands on the same edge as a read of the
// same row is forwarded. The cursor bit under the current position is implied by the
// cursor registers rather than stored; when the cursor leaves a pixel the stored cursor
// bit there is written as the pixel's toggled bit. Per-row valid flops stand in for the
// reset contents, so no clearing pass follows reset. A scan result waiting in the output
// register stops no row writes; only a second scan waits for it, and holds off all requests.
module led_matrix_cursor_painter_top #(
	parameter int GRID_SIZE = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	lmcp_req_if.sink                    req,
	lmcp_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lmcp_pkg::PaddrW-1:0] paddr,
	input  logic [lmcp_pkg::CfgW-1:0]   pwdata,
	output logic [lmcp_pkg::CfgW-1:0]   prdata,
	output logic                        pready
);

	localparam int AddrW = $clog2(GRID_SIZE);
	localparam int RowW  = 2 * GRID_SIZE;
	localparam int CW    = lmcp_pkg::CoordW;
	localparam logic [GRID_SIZE-1:0] ColOne  = GRID_SIZE'(1);
	localparam logic [AddrW-1:0]     LastRow = AddrW'(GRID_SIZE - 1);

	typedef enum logic [1:0] {
		OP_NOP  = 2'd0,
		OP_JOY  = 2'd1,
		OP_BTN  = 2'd2,
		OP_SCAN = 2'd3
	} op_t;

	// one coordinate step, kept when the target lies outside [lo, hi]
	function automatic logic [CW-1:0] step_coord(input logic [CW-1:0] cur, input logic inc,
			input logic dec, input logic [CW-1:0] lo, input logic [CW-1:0] hi);
		logic [CW:0] nxt;
		logic        ok;
		nxt = {1'b0, cur};
		if (inc) begin
			nxt = nxt + (CW+1)'(1);
		end else if (dec) begin
			nxt = nxt - (CW+1)'(1);
		end
		ok = (inc || dec) && (nxt >= {1'b0, lo}) && (nxt <= {1'b0, hi});
		return ok ? nxt[CW-1:0] : cur;
	endfunction

	// ---------------------------------------------------------------- configuration
	lmcp_pkg::bounds_t bounds;

	lmcp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.bounds  (bounds)
	);

	// ---------------------------------------------------------------- state registers
	logic [CW-1:0]    cur_row_q, cur_col_q;
	logic [AddrW-1:0] scan_cnt_q;
	logic [GRID_SIZE-1:0] row_valid_q;

	// write-back of the previous cycle, for forwarding
	logic             wr_valid_q;
	logic [AddrW-1:0] wr_addr_q;
	logic [RowW-1:0]  wr_data_q;

	// read stage
	logic                 valid_s1;
	op_t                  op_s1;
	logic [AddrW-1:0]     addr_s1;
	logic [GRID_SIZE-1:0] colbit_s1;
	logic                 hit_s1;
	logic [CW-1:0]        cur_row_s1, cur_col_s1;

	// output register
	logic                          out_valid_q;
	logic [lmcp_pkg::PatW-1:0]     pat_q;
	logic [lmcp_pkg::RowIdxW-1:0]  ridx_q;
	logic                          last_q;
	logic [CW-1:0]                 orow_q, ocol_q;

	// ---------------------------------------------------------------- acceptance stage
	logic                 out_free, adv, accept;
	logic                 on_grid;
	logic [CW-1:0]        cur_row_m1, cur_col_m1;
	logic [AddrW-1:0]     cur_addr, addr0;
	logic [GRID_SIZE-1:0] colbit0;
	logic                 row_inc, row_dec, col_inc, col_dec, move_any;
	op_t                  op0;

	assign out_free = !out_valid_q || rsp.ready;
	// only a scan needs the output register; row writes always drain
	assign adv      = !valid_s1 || (op_s1 != OP_SCAN) || out_free;
	assign req.ready = adv;
	assign accept   = req.valid && adv;

	assign on_grid = (cur_row_q >= lmcp_pkg::COORD_ONE)
		&& ({1'b0, cur_row_q} <= (CW+1)'(GRID_SIZE))
		&& (cur_col_q >= lmcp_pkg::COORD_ONE)
		&& ({1'b0, cur_col_q} <= (CW+1)'(GRID_SIZE));
	assign cur_row_m1 = cur_row_q - lmcp_pkg::COORD_ONE;
	assign cur_col_m1 = cur_col_q - lmcp_pkg::COORD_ONE;
	assign cur_addr   = cur_row_m1[AddrW-1:0];
	assign colbit0    = on_grid ? (ColOne << cur_col_m1) : '0;

	always_comb begin
		row_inc = 1'b0;
		row_dec = 1'b0;
		col_inc = 1'b0;
		col_dec = 1'b0;
		case (req.joystick_code)
			lmcp_pkg::JOY_ROW_INC_A, lmcp_pkg::JOY_ROW_INC_B: row_inc = 1'b1;
			lmcp_pkg::JOY_ROW_DEC_A, lmcp_pkg::JOY_ROW_DEC_B: row_dec = 1'b1;
			lmcp_pkg::JOY_COL_DEC_A, lmcp_pkg::JOY_COL_DEC_B: col_dec = 1'b1;
			lmcp_pkg::JOY_COL_INC_A, lmcp_pkg::JOY_COL_INC_B: col_inc = 1'b1;
			default: row_inc = 1'b0;
		endcase
	end

	assign move_any = row_inc || row_dec || col_inc || col_dec;

	always_comb begin
		case (req.action)
			lmcp_pkg::ACT_JOY:  op0 = (move_any && on_grid) ? OP_JOY : OP_NOP;
			lmcp_pkg::ACT_BTN:  op0 = on_grid ? OP_BTN : OP_NOP;
			lmcp_pkg::ACT_SCAN: op0 = OP_SCAN;
			default:            op0 = OP_NOP;
		endcase
	end

	assign addr0 = (req.action == lmcp_pkg::ACT_SCAN) ? scan_cnt_q : cur_addr;

	// advance cursor and scan position as soon as the request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q  <= lmcp_pkg::COORD_ONE;
			cur_col_q  <= lmcp_pkg::COORD_ONE;
			scan_cnt_q <= '0;
		end else if (accept) begin
			if (req.action == lmcp_pkg::ACT_JOY && move_any) begin
				cur_row_q <= step_coord(cur_row_q, row_inc, row_dec,
					bounds.row_min, bounds.row_max);
				cur_col_q <= step_coord(cur_col_q, col_inc, col_dec,
					bounds.col_min, bounds.col_max);
			end
			if (req.action == lmcp_pkg::ACT_SCAN) begin
				scan_cnt_q <= (scan_cnt_q == LastRow) ? '0 : scan_cnt_q + AddrW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= OP_NOP;
		end else if (adv) begin
			valid_s1 <= accept;
			op_s1    <= accept ? op0 : OP_NOP;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1    <= addr0;
			colbit_s1  <= colbit0;
			hit_s1     <= on_grid && (cur_addr == scan_cnt_q);
			cur_row_s1 <= cur_row_q;
			cur_col_s1 <= cur_col_q;
		end
	end

	// ---------------------------------------------------------------- row store
	logic [RowW-1:0]      ram_rdata, row_rd, row_wr;
	logic [GRID_SIZE-1:0] tog_rd, curs_rd, lit;
	logic                 ram_we;

	lmcp_ram #(
		.Width (RowW),
		.Depth (GRID_SIZE)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (row_wr),
		.re    (accept),
		.raddr (addr0),
		.rdata (ram_rdata)
	);

	// forward the write that landed on the read edge; unwritten rows read as reset
	always_comb begin
		if (wr_valid_q && (wr_addr_q == addr_s1)) begin
			row_rd = wr_data_q;
		end else if (!row_valid_q[addr_s1]) begin
			row_rd = {{GRID_SIZE{1'b0}}, ((addr_s1 == '0) ? ColOne : {GRID_SIZE{1'b0}})};
		end else begin
			row_rd = ram_rdata;
		end
	end

	assign tog_rd  = row_rd[RowW-1:GRID_SIZE];
	assign curs_rd = row_rd[GRID_SIZE-1:0];

	always_comb begin
		case (op_s1)
			// leaving a pixel: its cursor bit becomes its toggled bit
			OP_JOY:  row_wr = {tog_rd, (curs_rd & ~colbit_s1) | (tog_rd & colbit_s1)};
			OP_BTN:  row_wr = {tog_rd ^ colbit_s1, curs_rd};
			default: row_wr = row_rd;
		endcase
	end

	assign ram_we = valid_s1 && ((op_s1 == OP_JOY) || (op_s1 == OP_BTN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q  <= 1'b0;
			row_valid_q <= '0;
		end else begin
			if (adv) begin
				wr_valid_q <= ram_we;
			end
			if (ram_we) begin
				row_valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= row_wr;
		end
	end

	// ---------------------------------------------------------------- scan result
	logic [lmcp_pkg::ByteW-1:0] mask8, sel8;
	logic [lmcp_pkg::PatW-1:0]  pat_s1;
	logic                       out_load;

	assign lit = curs_rd | tog_rd | (hit_s1 ? colbit_s1 : '0);

	for (genvar g = 0; g < lmcp_pkg::ByteW; g++) begin : g_mask
		if (g < GRID_SIZE) begin : g_in
			assign mask8[g] = lit[g];
		end else begin : g_out
			assign mask8[g] = 1'b0;
		end
	end

	assign sel8   = ~(lmcp_pkg::ByteW'(1) << addr_s1);
	assign pat_s1 = (|lit) ? {sel8, mask8} : '0;
	assign out_load = valid_s1 && (op_s1 == OP_SCAN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pat_q  <= pat_s1;
			ridx_q <= lmcp_pkg::RowIdxW'(addr_s1);
			last_q <= (addr_s1 == LastRow);
			orow_q <= cur_row_s1;
			ocol_q <= cur_col_s1;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.row_pattern = pat_q;
	assign rsp.row_index   = ridx_q;
	assign rsp.last_row    = last_q;
	assign rsp.cursor_row  = orow_q;
	assign rsp.cursor_col  = ocol_q;

`ifndef SYNTH
	// a scan held by a full output register keeps its row and blocks new requests
	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (op_s1 == OP_SCAN) && !out_free
		|=> valid_s1 && (op_s1 == OP_SCAN) && $stable(addr_s1))
		else $error("stalled scan lost its row");

	a_scan_block: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (op_s1 == OP_SCAN) && out_valid_q && !rsp.ready |-> !req.ready)
		else $error("request taken while scan result blocked");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && (op_s1 == OP_SCAN)))
		else $error("result without a scan in the read stage");

	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid_q |-> row_valid_q[wr_addr_q])
		else $error("forwarded row not marked written");
`endif

endmodule

[tb/sv/lmcp_paint_checker.sv]
// Checker for the LED matrix cursor painter: tracks cursor and bitmaps, checks each row word.
`timescale 1ns / 100ps
module lmcp_paint_checker
	import lmcp_pkg::*;
#(
	parameter int GRID = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	lmcp_req_if               req,
	lmcp_rsp_if               rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [PaddrW-1:0] paddr,
	input  logic [CfgW-1:0]   pwdata,
	output int                mismatches,
	output int                outstanding
);

	typedef struct packed {
		logic [PatW-1:0]    row_pattern;
		logic [RowIdxW-1:0] row_index;
		logic               last_row;
		logic [CoordW-1:0]  cursor_row;
		logic [CoordW-1:0]  cursor_col;
	} row_word_t;

	bounds_t            limits;
	logic [CoordW-1:0]  at_row;
	logic [CoordW-1:0]  at_col;
	logic [ByteW-1:0]   cursor_bits [GRID];
	logic [ByteW-1:0]   toggle_bits [GRID];
	logic [RowIdxW-1:0] scan_row;
	row_word_t          words_due [$];

	function automatic bit on_grid(logic [CoordW-1:0] r, logic [CoordW-1:0] c);
		return r >= 1 && r <= GRID && c >= 1 && c <= GRID;
	endfunction

	function automatic void clear_state();
		limits = '{row_min: COORD_ONE, row_max: COORD_EIGHT,
			col_min: COORD_ONE, col_max: COORD_EIGHT};
		at_row = COORD_ONE;
		at_col = COORD_ONE;
		for (int i = 0; i < GRID; i++) begin
			cursor_bits[i] = '0;
			toggle_bits[i] = '0;
		end
		cursor_bits[0] = ByteW'(1);
		scan_row = '0;
		mismatches = 0;
		words_due.delete();
	endfunction

	// clear the old cursor bit unless toggled, step within bounds, set the new bit
	function automatic void step_cursor(int dr, int dc);
		int nr;
		int nc;
		nr = int'(at_row) + dr;
		nc = int'(at_col) + dc;
		if (on_grid(at_row, at_col) && !toggle_bits[at_row-1][at_col-1])
			cursor_bits[at_row-1][at_col-1] = 1'b0;
		if (nr >= int'(limits.row_min) && nr <= int'(limits.row_max))
			at_row = CoordW'(nr);
		if (nc >= int'(limits.col_min) && nc <= int'(limits.col_max))
			at_col = CoordW'(nc);
		if (on_grid(at_row, at_col))
			cursor_bits[at_row-1][at_col-1] = 1'b1;
	endfunction

	function automatic void take_request(logic [ActW-1:0] act, logic [CodeW-1:0] code);
		row_word_t        w;
		logic [ByteW-1:0] lit;
		case (act)
		ACT_JOY: begin
			case (code)
			JOY_ROW_INC_A, JOY_ROW_INC_B: step_cursor(1, 0);
			JOY_ROW_DEC_A, JOY_ROW_DEC_B: step_cursor(-1, 0);
			JOY_COL_DEC_A, JOY_COL_DEC_B: step_cursor(0, -1);
			JOY_COL_INC_A, JOY_COL_INC_B: step_cursor(0, 1);
			default: ;
			endcase
		end
		ACT_BTN: begin
			if (on_grid(at_row, at_col))
				toggle_bits[at_row-1][at_col-1] = ~toggle_bits[at_row-1][at_col-1];
		end
		ACT_SCAN: begin
			lit = cursor_bits[scan_row] | toggle_bits[scan_row];
			w.row_pattern = (lit != '0) ? {~(ByteW'(1) << scan_row), lit} : '0;
			w.row_index   = scan_row;
			w.last_row    = (int'(scan_row) == GRID - 1);
			w.cursor_row  = at_row;
			w.cursor_col  = at_col;
			words_due.push_back(w);
			scan_row = RowIdxW'((int'(scan_row) + 1) % GRID);
		end
		default: ;
		endcase
	endfunction

	function automatic void set_bound(logic [1:0] idx, logic [CoordW-1:0] value);
		case (idx)
		REG_ROW_MIN: limits.row_min = value;
		REG_ROW_MAX: limits.row_max = value;
		REG_COL_MIN: limits.col_min = value;
		REG_COL_MAX: limits.col_max = value;
		default: ;
		endcase
	endfunction

	function automatic void note_mismatch(string msg);
		if (mismatches < 10)
			$display("%0t: MISMATCH %s", $time, msg);
		mismatches++;
	endfunction

	function automatic void check_word(row_word_t got);
		row_word_t want;
		if (words_due.size() == 0) begin
			note_mismatch($sformatf("unexpected row word pat %h row %0d", got.row_pattern,
				got.row_index));
			return;
		end
		want = words_due.pop_front();
		if (got !== want)
			note_mismatch($sformatf(
				"exp pat %h row %0d last %0b cur %0d,%0d / got pat %h row %0d last %0b cur %0d,%0d",
				want.row_pattern, want.row_index, want.last_row, want.cursor_row,
				want.cursor_col, got.row_pattern, got.row_index, got.last_row,
				got.cursor_row, got.cursor_col));
	endfunction

	// results first: a word leaving at this edge belongs to an older request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			if (rsp.valid && rsp.ready)
				check_word({rsp.row_pattern, rsp.row_index, rsp.last_row, rsp.cursor_row,
					rsp.cursor_col});
			if (psel && penable && pwrite && pready)
				set_bound(paddr[PaddrW-1:2], pwdata[CoordW-1:0]);
			if (req.valid && req.ready)
				take_request(req.action, req.joystick_code);
		end
		outstanding <= words_due.size();
	end

endmodule

[tb/sv/led_matrix_cursor_painter_top_test.sv]
// Testbench top for the LED matrix cursor painter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module led_matrix_cursor_painter_top_test;
	import lmcp_pkg::*;

	localparam int GRID       = 8;
	localparam int PHASES     = 8;
	localparam int PHASE_REQS = 96;
	// the one action code the block has no use for
	localparam logic [ActW-1:0] ACT_UNUSED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [PaddrW-1:0] paddr;
	logic [CfgW-1:0]   pwdata;
	logic [CfgW-1:0]   prdata;
	logic              pready;
	int                idle_pct = 0;
	int                stall_pct = 0;
	int                mismatches;
	int                outstanding;

	lmcp_req_if req ();
	lmcp_rsp_if rsp ();

	led_matrix_cursor_painter_top #(
		.GRID_SIZE(GRID)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	lmcp_paint_checker #(
		.GRID(GRID)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: hold ready low in reset, then stall at the rate the phase asks.
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= arst_n && ($urandom_range(99) >= stall_pct);
		end
	end

	// Boundary settings per phase: full grid, boxes, a single point, bounds beyond
	// the grid on both sides, inverted bounds that block every move.
	function automatic bounds_t phase_bounds(int p);
		case (p)
		1: return '{row_min: 4'd3, row_max: 4'd6, col_min: 4'd2, col_max: 4'd5};
		2: return '{row_min: 4'd4, row_max: 4'd4, col_min: 4'd7, col_max: 4'd7};
		3: return '{row_min: 4'd0, row_max: 4'd15, col_min: 4'd0, col_max: 4'd15};
		4: return '{row_min: COORD_EIGHT, row_max: COORD_EIGHT, col_min: COORD_ONE,
			col_max: COORD_EIGHT};
		5: return '{row_min: 4'd6, row_max: 4'd2, col_min: COORD_EIGHT, col_max: COORD_ONE};
		6: return '{row_min: COORD_ONE, row_max: COORD_EIGHT, col_min: 4'd0, col_max: 4'd9};
		default: return '{row_min: COORD_ONE, row_max: COORD_EIGHT, col_min: COORD_ONE,
			col_max: COORD_EIGHT};
		endcase
	endfunction

	// One register write: setup, access, then drop psel in a step of its own so a
	// following write never lowers and raises it in the same step.
	task automatic write_bound(logic [1:0] idx, logic [CoordW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PaddrW'({idx, 2'b00});
		pwdata  <= CfgW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_bounds(bounds_t b);
		write_bound(REG_ROW_MIN, b.row_min);
		write_bound(REG_ROW_MAX, b.row_max);
		write_bound(REG_COL_MIN, b.col_min);
		write_bound(REG_COL_MAX, b.col_max);
	endtask

	// Send one request. Idle first at the phase rate with junk on the payload; keep
	// valid high straight into the next request when no gap is drawn.
	task automatic send_request(logic [ActW-1:0] act, logic [CodeW-1:0] code);
		while ($urandom_range(99) < idle_pct) begin
			req.valid         <= 1'b0;
			req.action        <= ActW'($urandom);
			req.joystick_code <= CodeW'($urandom);
			@(posedge clk);
		end
		req.valid         <= 1'b1;
		req.action        <= act;
		req.joystick_code <= code;
		do @(posedge clk); while (!req.ready);
	endtask

	// Drop valid, wait until every row word has come back (with a guard), then let
	// the pipeline run dry: moves and toggles leave no word behind to wait for.
	task automatic settle();
		int guard;
		guard = 0;
		req.valid <= 1'b0;
		do begin
			@(posedge clk);
			guard++;
		end while (outstanding != 0 && guard < 5000);
		repeat (6) @(posedge clk);
	endtask

	task automatic directed_requests();
		send_request(ACT_SCAN, '0);
		// every joystick code from the home corner, ignored codes included
		for (int c = 0; c < 16; c++)
			send_request(ACT_JOY, CodeW'(c));
		// back at row 1, column 1: both of these hit the boundary
		send_request(ACT_JOY, JOY_COL_DEC_A);
		send_request(ACT_JOY, JOY_ROW_DEC_B);
		// toggle, walk off and back, untoggle, walk off again
		send_request(ACT_BTN, '0);
		send_request(ACT_JOY, JOY_COL_INC_A);
		send_request(ACT_JOY, JOY_COL_DEC_B);
		send_request(ACT_BTN, '0);
		send_request(ACT_JOY, JOY_COL_INC_B);
		send_request(ACT_UNUSED, '1);
		send_request(ACT_SCAN, '0);
		send_request(ACT_SCAN, '0);
	endtask

	// Mostly moves, presses and scans with random codes; now and then a whole frame
	// of scans in a row. Ignored requests go out too but do not advance the count.
	task automatic random_requests(int count);
		int               done;
		int               roll;
		logic [ActW-1:0]  act;
		logic [CodeW-1:0] code;
		done = 0;
		while (done < count) begin
			roll = $urandom_range(99);
			if (roll < 6) begin
				for (int i = 0; i < GRID; i++)
					send_request(ACT_SCAN, CodeW'($urandom));
				done += GRID;
			end else begin
				if (roll < 45)
					act = ACT_JOY;
				else if (roll < 60)
					act = ACT_BTN;
				else if (roll < 95)
					act = ACT_SCAN;
				else
					act = ACT_UNUSED;
				if ($urandom_range(9) < 8)
					code = CodeW'($urandom_range(JOY_ROW_DEC_B, JOY_COL_INC_A));
				else
					code = CodeW'($urandom_range(15));
				send_request(act, code);
				if (act == ACT_BTN || act == ACT_SCAN ||
						(act == ACT_JOY && code >= JOY_COL_INC_A && code <= JOY_ROW_DEC_B))
					done++;
			end
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		req.valid         = 1'b0;
		req.action        = ACT_JOY;
		req.joystick_code = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			// block is idle here: nothing in flight, pipeline drained
			apply_bounds(phase_bounds(p));
			case (p % 4)
			0: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct  = 58;
				stall_pct = 0;
			end
			2: begin
				idle_pct  = 0;
				stall_pct = 58;
			end
			default: begin
				idle_pct  = 9;
				stall_pct = 9;
			end
			endcase
			if (p == 0)
				directed_requests();
			random_requests(PHASE_REQS);
			settle();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
